@@ rtl/msx_pkg.sv @@
// Shared types and constants for the MIPS subset execute stage.
// Holds the opcode and status encodings and the execute result bundle.
// No dependencies.
package msx_pkg;

    localparam int DATA_W  = 32;
    localparam int REG_AW  = 5;
    localparam int RF_DEPTH = 32;
    localparam int IMM_W   = 16;
    localparam int TGT_W   = 26;

    typedef enum logic [4:0] {
        OP_ADDU = 5'd0,
        OP_SUBU = 5'd1,
        OP_AND  = 5'd2,
        OP_OR   = 5'd3,
        OP_XOR  = 5'd4,
        OP_NOR  = 5'd5,
        OP_SLL  = 5'd6,
        OP_SRL  = 5'd7,
        OP_JR   = 5'd8,
        OP_ADDI = 5'd9,
        OP_ANDI = 5'd10,
        OP_ORI  = 5'd11,
        OP_XORI = 5'd12,
        OP_LW   = 5'd13,
        OP_SW   = 5'd14,
        OP_BEQ  = 5'd15,
        OP_J    = 5'd16
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_OP   = 2'd1,
        ST_BAD_JUMP = 2'd2
    } status_t;

    // Everything the execute step decides for one instruction
    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   result;
        logic [DATA_W-1:0]   pc_next;
        logic                rf_we;
        logic [REG_AW-1:0]   rf_addr;
        logic                is_load;
        logic                is_store;
        logic [DATA_W-1:0]   ea;
        logic [7:0]          store_byte;
    } exec_t;

    function automatic logic [DATA_W-1:0] sext16(input logic [IMM_W-1:0] v);
        return {{(DATA_W-IMM_W){v[IMM_W-1]}}, v};
    endfunction

    function automatic logic [DATA_W-1:0] sext8(input logic [7:0] v);
        return {{(DATA_W-8){v[7]}}, v};
    endfunction

endpackage

@@ rtl/msx_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds when the read enable is low. No dependencies.
module msx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, returns old data on a same-address write
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/msx_alu.sv @@
// Execute logic for one decoded instruction: ALU, branch and jump decisions.
// Depends on msx_pkg for opcodes, status codes and the exec_t bundle.
module msx_alu (
    input  logic [4:0]                     op_i,
    input  logic [msx_pkg::REG_AW-1:0]     rd_i,
    input  logic [msx_pkg::REG_AW-1:0]     rt_i,
    input  logic [4:0]                     sh_i,
    input  logic [msx_pkg::IMM_W-1:0]      imm_i,
    input  logic [msx_pkg::TGT_W-1:0]      tgt_i,
    input  logic [msx_pkg::DATA_W-1:0]     a_i,
    input  logic [msx_pkg::DATA_W-1:0]     b_i,
    input  logic [msx_pkg::DATA_W-1:0]     pc_i,
    input  logic [msx_pkg::TGT_W-1:0]      max_tgt_i,
    output msx_pkg::exec_t                 ex_o
);
    import msx_pkg::*;

    logic [DATA_W-1:0] imm_s;
    logic [DATA_W-1:0] imm_z;
    logic [DATA_W-1:0] br_pc;

    assign imm_s = sext16(imm_i);
    assign imm_z = {{(DATA_W-IMM_W){1'b0}}, imm_i};
    assign br_pc = pc_i + {imm_s[DATA_W-3:0], 2'b00};

    // Decode and execute
    always_comb begin
        ex_o            = '0;
        ex_o.status     = ST_OK;
        ex_o.pc_next    = pc_i;
        ex_o.rf_addr    = rd_i;
        ex_o.ea         = a_i + imm_s;
        ex_o.store_byte = b_i[7:0];
        case (op_i)
            OP_ADDU: begin ex_o.result = a_i + b_i;      ex_o.rf_we = 1'b1; end
            OP_SUBU: begin ex_o.result = a_i - b_i;      ex_o.rf_we = 1'b1; end
            OP_AND:  begin ex_o.result = a_i & b_i;      ex_o.rf_we = 1'b1; end
            OP_OR:   begin ex_o.result = a_i | b_i;      ex_o.rf_we = 1'b1; end
            OP_XOR:  begin ex_o.result = a_i ^ b_i;      ex_o.rf_we = 1'b1; end
            OP_NOR:  begin ex_o.result = ~(a_i | b_i);   ex_o.rf_we = 1'b1; end
            OP_SLL:  begin ex_o.result = b_i << sh_i;    ex_o.rf_we = 1'b1; end
            OP_SRL:  begin ex_o.result = b_i >> sh_i;    ex_o.rf_we = 1'b1; end
            OP_JR: begin
                ex_o.result  = a_i;
                ex_o.pc_next = a_i;
            end
            OP_ADDI: begin
                ex_o.result = a_i + imm_s; ex_o.rf_we = 1'b1; ex_o.rf_addr = rt_i;
            end
            OP_ANDI: begin
                ex_o.result = a_i & imm_z; ex_o.rf_we = 1'b1; ex_o.rf_addr = rt_i;
            end
            OP_ORI: begin
                ex_o.result = a_i | imm_z; ex_o.rf_we = 1'b1; ex_o.rf_addr = rt_i;
            end
            OP_XORI: begin
                ex_o.result = a_i ^ imm_z; ex_o.rf_we = 1'b1; ex_o.rf_addr = rt_i;
            end
            OP_LW: begin
                ex_o.is_load = 1'b1; ex_o.rf_we = 1'b1; ex_o.rf_addr = rt_i;
            end
            OP_SW: begin
                ex_o.is_store = 1'b1;
            end
            OP_BEQ: begin
                if (a_i == b_i) begin
                    ex_o.pc_next = br_pc;
                    ex_o.result  = br_pc;
                end
            end
            OP_J: begin
                if (tgt_i > max_tgt_i) begin
                    ex_o.status = ST_BAD_JUMP;
                end else begin
                    ex_o.pc_next = {{(DATA_W-TGT_W){1'b0}}, tgt_i};
                    ex_o.result  = {{(DATA_W-TGT_W){1'b0}}, tgt_i};
                end
            end
            default: begin
                ex_o.status = ST_BAD_OP;
            end
        endcase
    end

endmodule

@@ rtl/mips_subset_execute_stage.sv @@
// Top level of the MIPS subset execute stage: register file, data memory, PC.
// Depends on msx_pkg, msx_alu and msx_ram.
//
// Usage: one decoded instruction per s_ transaction, one result per m_
// transaction (status, value written or moved, PC after the instruction).
// cfg_max_jump_target sets the largest accepted j target; write it only while
// the block is idle. cfg_ready is always high.
// A result passes stage 1, stages 2 to 5 and the output register before m_.
// Throughput: one instruction per cycle while no interlock or output stall
// holds the pipeline. An instruction whose rs or rt is the destination of a
// lw still in the three address stages waits for it, a wait set by the modulo
// address pipeline in front of the data memory port. Everything else forwards
// from the later stages. Reset: clears the PC and the register file valid bits,
// sets the jump limit to 1023, then sweeps the data memory to zero, one byte
// per cycle over all MEM_DEPTH bytes, with s_ready low. Config writes are
// taken during the sweep. Stall: a two-entry output (register plus skid) lets
// the pipeline run on while m_ready is low until the skid fills; then the whole pipeline holds.
module mips_subset_execute_stage #(
    parameter int MEM_DEPTH = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [4:0]                     s_operation,
    input  logic [msx_pkg::REG_AW-1:0]     s_dest_reg,
    input  logic [msx_pkg::REG_AW-1:0]     s_src_reg,
    input  logic [msx_pkg::REG_AW-1:0]     s_tgt_reg,
    input  logic [4:0]                     s_shift_amount,
    input  logic [msx_pkg::IMM_W-1:0]      s_imm16,
    input  logic [msx_pkg::TGT_W-1:0]      s_jump_target,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [msx_pkg::DATA_W-1:0]     m_result_value,
    output logic [msx_pkg::DATA_W-1:0]     m_pc_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [msx_pkg::TGT_W-1:0]      cfg_max_jump_target
);
    import msx_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);
    localparam logic [DATA_W-1:0] DEPTH32 = 32'(MEM_DEPTH);
    localparam logic [DATA_W-1:0] RECIP = 32'((64'd1 << 32) / MEM_DEPTH);
    localparam logic [TGT_W-1:0] MAX_TGT_RESET = 26'd1023;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] result;
        logic [DATA_W-1:0] pc;
    } out_t;

    // Control and config state
    logic                 clear_busy_reg;
    logic [AW-1:0]        clr_cnt_reg;
    logic [TGT_W-1:0]     max_tgt_reg;
    logic [DATA_W-1:0]    pc_reg;
    logic [RF_DEPTH-1:0]  rf_valid_reg;
    logic                 wb_valid_reg;
    logic [REG_AW-1:0]    wb_addr_reg;
    logic [DATA_W-1:0]    wb_data_reg;

    // Stage 1: operand fetch and execute
    logic                 s1_valid_reg;
    logic                 s1_first_reg;
    logic [4:0]           s1_op_reg;
    logic [REG_AW-1:0]    s1_rd_reg;
    logic [REG_AW-1:0]    s1_rs_reg;
    logic [REG_AW-1:0]    s1_rt_reg;
    logic [4:0]           s1_sh_reg;
    logic [IMM_W-1:0]     s1_imm_reg;
    logic [TGT_W-1:0]     s1_tgt_reg;
    logic [DATA_W-1:0]    a_hold_reg;
    logic [DATA_W-1:0]    b_hold_reg;

    // Stages 2 to 5: address reduction, memory access, writeback
    logic                 s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    exec_t                s2_ex_reg, s3_ex_reg, s4_ex_reg, s5_ex_reg;
    logic [DATA_W-1:0]    s3_q_reg;
    logic [DATA_W-1:0]    s4_prod_reg;

    // Output register and skid
    logic                 out_valid_reg;
    out_t                 out_reg;
    logic                 skid_valid_reg;
    out_t                 skid_reg;

    logic                 adv;
    logic                 hazard;
    logic                 s1_exit;
    logic                 s_accept;
    logic [DATA_W-1:0]    rf_a_rdata, rf_b_rdata;
    logic [DATA_W-1:0]    base_a, base_b, op_a, op_b;
    exec_t                ex;
    exec_t                s4_out;
    logic                 commit_we;
    logic [DATA_W-1:0]    s5_data;
    logic [63:0]          s2_mul;
    logic [DATA_W-1:0]    s3_prod;
    logic [DATA_W-1:0]    s4_rem;
    logic [DATA_W-1:0]    s4_rem_fix;
    logic [AW-1:0]        s4_idx;
    logic                 dm_we, dm_re;
    logic [AW-1:0]        dm_waddr;
    logic [7:0]           dm_wdata;
    logic [7:0]           dm_rdata;
    out_t                 push_data;

    assign adv      = !skid_valid_reg;
    assign s1_exit  = s1_valid_reg && adv && !hazard;
    assign s_ready  = !clear_busy_reg && (!s1_valid_reg || s1_exit);
    assign s_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Register file, one copy per read port
    msx_ram #(.WIDTH(DATA_W), .DEPTH(RF_DEPTH)) u_rf_a (
        .clk(aclk), .we(commit_we), .waddr(s5_ex_reg.rf_addr), .wdata(s5_data),
        .re(s_accept), .raddr(s_src_reg), .rdata(rf_a_rdata)
    );
    msx_ram #(.WIDTH(DATA_W), .DEPTH(RF_DEPTH)) u_rf_b (
        .clk(aclk), .we(commit_we), .waddr(s5_ex_reg.rf_addr), .wdata(s5_data),
        .re(s_accept), .raddr(s_tgt_reg), .rdata(rf_b_rdata)
    );

    // Data memory
    msx_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_dmem (
        .clk(aclk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
        .re(dm_re), .raddr(s4_idx), .rdata(dm_rdata)
    );

    // Resolve committed register values: fresh RAM read or tracked value
    always_comb begin
        if (s1_first_reg) begin
            if (wb_valid_reg && wb_addr_reg == s1_rs_reg) begin
                base_a = wb_data_reg;
            end else begin
                base_a = rf_valid_reg[s1_rs_reg] ? rf_a_rdata : '0;
            end
            if (wb_valid_reg && wb_addr_reg == s1_rt_reg) begin
                base_b = wb_data_reg;
            end else begin
                base_b = rf_valid_reg[s1_rt_reg] ? rf_b_rdata : '0;
            end
        end else begin
            base_a = a_hold_reg;
            base_b = b_hold_reg;
        end
    end

    // Forward from in-flight writers, youngest first
    always_comb begin
        if (s2_valid_reg && s2_ex_reg.rf_we && s2_ex_reg.rf_addr == s1_rs_reg) begin
            op_a = s2_ex_reg.result;
        end else if (s3_valid_reg && s3_ex_reg.rf_we && s3_ex_reg.rf_addr == s1_rs_reg) begin
            op_a = s3_ex_reg.result;
        end else if (s4_valid_reg && s4_ex_reg.rf_we && s4_ex_reg.rf_addr == s1_rs_reg) begin
            op_a = s4_ex_reg.result;
        end else if (s5_valid_reg && s5_ex_reg.rf_we && s5_ex_reg.rf_addr == s1_rs_reg) begin
            op_a = s5_data;
        end else begin
            op_a = base_a;
        end
        if (s2_valid_reg && s2_ex_reg.rf_we && s2_ex_reg.rf_addr == s1_rt_reg) begin
            op_b = s2_ex_reg.result;
        end else if (s3_valid_reg && s3_ex_reg.rf_we && s3_ex_reg.rf_addr == s1_rt_reg) begin
            op_b = s3_ex_reg.result;
        end else if (s4_valid_reg && s4_ex_reg.rf_we && s4_ex_reg.rf_addr == s1_rt_reg) begin
            op_b = s4_ex_reg.result;
        end else if (s5_valid_reg && s5_ex_reg.rf_we && s5_ex_reg.rf_addr == s1_rt_reg) begin
            op_b = s5_data;
        end else begin
            op_b = base_b;
        end
    end

    // Interlock on a load whose data is not yet back
    always_comb begin
        hazard = 1'b0;
        if (s2_valid_reg && s2_ex_reg.is_load &&
            (s2_ex_reg.rf_addr == s1_rs_reg || s2_ex_reg.rf_addr == s1_rt_reg)) begin
            hazard = 1'b1;
        end
        if (s3_valid_reg && s3_ex_reg.is_load &&
            (s3_ex_reg.rf_addr == s1_rs_reg || s3_ex_reg.rf_addr == s1_rt_reg)) begin
            hazard = 1'b1;
        end
        if (s4_valid_reg && s4_ex_reg.is_load &&
            (s4_ex_reg.rf_addr == s1_rs_reg || s4_ex_reg.rf_addr == s1_rt_reg)) begin
            hazard = 1'b1;
        end
    end

    msx_alu u_alu (
        .op_i(s1_op_reg), .rd_i(s1_rd_reg), .rt_i(s1_rt_reg), .sh_i(s1_sh_reg),
        .imm_i(s1_imm_reg), .tgt_i(s1_tgt_reg), .a_i(op_a), .b_i(op_b),
        .pc_i(pc_reg), .max_tgt_i(max_tgt_reg), .ex_o(ex)
    );

    // Address reduction modulo MEM_DEPTH by reciprocal multiply
    assign s2_mul     = 64'(s2_ex_reg.ea) * 64'(RECIP);
    assign s3_prod    = 32'(s3_q_reg * DEPTH32);
    assign s4_rem     = s4_ex_reg.ea - s4_prod_reg;
    assign s4_rem_fix = (s4_rem >= DEPTH32) ? s4_rem - DEPTH32 : s4_rem;
    assign s4_idx     = s4_rem_fix[AW-1:0];

    // Report the wrapped address as the result of a store
    always_comb begin
        s4_out = s4_ex_reg;
        if (s4_ex_reg.is_store) begin
            s4_out.result = DATA_W'(s4_idx);
        end
    end

    // Data memory port: clearing sweep or stage 4 access
    assign dm_we    = clear_busy_reg || (adv && s4_valid_reg && s4_ex_reg.is_store);
    assign dm_waddr = clear_busy_reg ? clr_cnt_reg : s4_idx;
    assign dm_wdata = clear_busy_reg ? 8'd0 : s4_ex_reg.store_byte;
    assign dm_re    = adv && s4_valid_reg && s4_ex_reg.is_load;

    // Writeback value
    assign s5_data   = s5_ex_reg.is_load ? sext8(dm_rdata) : s5_ex_reg.result;
    assign commit_we = adv && s5_valid_reg && s5_ex_reg.rf_we;

    assign push_data.status = s5_ex_reg.status;
    assign push_data.result = s5_data;
    assign push_data.pc     = s5_ex_reg.pc_next;

    // Control state: reset sweep, config, PC, valid bits, writeback tracker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            max_tgt_reg    <= MAX_TGT_RESET;
            pc_reg         <= '0;
            rf_valid_reg   <= '0;
            wb_valid_reg   <= 1'b0;
        end else begin
            if (clear_busy_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(MEM_DEPTH - 1)) begin
                    clear_busy_reg <= 1'b0;
                end
            end
            if (cfg_valid) begin
                max_tgt_reg <= cfg_max_jump_target;
            end
            if (s1_exit) begin
                pc_reg <= ex.pc_next;
            end
            if (commit_we) begin
                rf_valid_reg[s5_ex_reg.rf_addr] <= 1'b1;
                wb_valid_reg <= 1'b1;
            end
        end
    end

    // Writeback tracker payload
    always_ff @(posedge aclk) begin
        if (commit_we) begin
            wb_addr_reg <= s5_ex_reg.rf_addr;
            wb_data_reg <= s5_data;
        end
    end

    // Stage 1: load, hold with tracked operands, or drain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
            s1_first_reg <= 1'b1;
        end else if (s1_exit) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_first_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_op_reg  <= s_operation;
            s1_rd_reg  <= s_dest_reg;
            s1_rs_reg  <= s_src_reg;
            s1_rt_reg  <= s_tgt_reg;
            s1_sh_reg  <= s_shift_amount;
            s1_imm_reg <= s_imm16;
            s1_tgt_reg <= s_jump_target;
        end else begin
            a_hold_reg <= (commit_we && s5_ex_reg.rf_addr == s1_rs_reg) ? s5_data : base_a;
            b_hold_reg <= (commit_we && s5_ex_reg.rf_addr == s1_rt_reg) ? s5_data : base_b;
        end
    end

    // Stages 2 to 5 advance together; stage 2 takes a bubble on interlock
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_exit;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_ex_reg   <= ex;
            s3_ex_reg   <= s2_ex_reg;
            s3_q_reg    <= s2_mul[63:32];
            s4_ex_reg   <= s3_ex_reg;
            s4_prod_reg <= s3_prod;
            s5_ex_reg   <= s4_out;
        end
    end

    // Output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !out_valid_reg) begin
            out_valid_reg  <= skid_valid_reg || (adv && s5_valid_reg);
            skid_valid_reg <= 1'b0;
        end else if (adv && s5_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !out_valid_reg) begin
            out_reg <= skid_valid_reg ? skid_reg : push_data;
        end else if (adv && s5_valid_reg) begin
            skid_reg <= push_data;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_reg.status;
    assign m_result_value = out_reg.result;
    assign m_pc_value     = out_reg.pc;

    // A stalled instruction must leave a bubble in stage 2
    a_interlock_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && hazard && adv) |=> !s2_valid_reg)
        else $error("instruction issued past a pending load");

    // The skid entry is only used behind a waiting output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full with output empty");

    // The pipeline is empty during the memory sweep
    a_empty_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy_reg |-> !(s1_valid_reg || s2_valid_reg || s3_valid_reg ||
                             s4_valid_reg || s5_valid_reg))
        else $error("instruction in flight during memory sweep");

    // PC changes only when an instruction leaves execute
    a_pc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_exit |=> $stable(pc_reg))
        else $error("PC changed without an executing instruction");

endmodule
